// ----- rtl/core/alid_pkg.sv -----
// ----------------------------------------------------------------------------
// alid_pkg
// Shared types and codes of the array list: command and status codes, and
// the control and status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package alid_pkg;

  localparam int CMD_W   = 3;
  localparam int POS_W   = 6;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_SEARCH = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_REJECT    = 2'd1,
    ST_NOT_FOUND = 2'd2
  } stat_e;

  // Source of a memory write.
  typedef enum logic [1:0] {
    WR_TAIL  = 2'd0,
    WR_POS   = 2'd1,
    WR_SHIFT = 2'd2
  } wr_e;

  typedef struct packed {
    logic  load;
    logic  ptr_init;
    logic  ptr_step;
    logic  rd_en;
    logic  wr_en;
    wr_e   wr_mode;
    logic  cnt_inc;
    logic  cnt_dec;
    logic  stat_wr;
    stat_e stat;
    logic  cap_idx;
    logic  cap_data;
    logic  out_load;
  } ctl_t;

  typedef struct packed {
    cmd_e cmd;
    logic reject;
    logic need_shift;
    logic empty;
    logic at_last;
    logic rd_vld;
    logic match;
  } sts_t;

endpackage

// ----- rtl/core/array_list_insert_delete.sv -----
// ----------------------------------------------------------------------------
// array_list_insert_delete
// Ordered list of words held in an on-chip memory with an occupancy count;
// append, insert, delete, search and read commands, one result per command.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o  | command, position, element
//  out     | output    | out_valid_o / out_stall_i| status, found_index, read_data,
//          |           |                          | count
//
// One command is worked on at a time. Insert and delete move one entry per cycle
// through the entry memory, which is read and written in the same cycle. Search stops
// at the first match. The entry memory needs no clearing after reset. A waiting result
// does not block the next command until that command's own result is ready; that
// result then waits while the output stalls.
module array_list_insert_delete #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [alid_pkg::CMD_W-1:0]   command_i,
  input  logic [alid_pkg::POS_W-1:0]   position_i,
  input  logic [alid_pkg::DATA_W-1:0]  element_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [alid_pkg::STAT_W-1:0]  status_o,
  output logic [alid_pkg::POS_W-1:0]   found_index_o,
  output logic [alid_pkg::DATA_W-1:0]  read_data_o,
  output logic [alid_pkg::COUNT_W-1:0] count_o
);
  import alid_pkg::*;

  ctl_t ctl;
  sts_t sts;

  alid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  alid_dpath #(
    .DEPTH     (DEPTH),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .command_i    (command_i),
    .position_i   (position_i),
    .element_i    (element_i),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .status_o     (status_o),
    .found_index_o(found_index_o),
    .read_data_o  (read_data_o),
    .count_o      (count_o)
  );

endmodule

// ----- rtl/core/alid_dpath.sv -----
// ----------------------------------------------------------------------------
// alid_dpath
// Datapath of the array list: entry memory, occupancy count, scan pointer,
// registered memory read and the result register.
// ----------------------------------------------------------------------------
module alid_dpath #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [alid_pkg::CMD_W-1:0]   command_i,
  input  logic [alid_pkg::POS_W-1:0]   position_i,
  input  logic [alid_pkg::DATA_W-1:0]  element_i,
  input  alid_pkg::ctl_t               ctl_i,
  output alid_pkg::sts_t               sts_o,
  output logic [alid_pkg::STAT_W-1:0]  status_o,
  output logic [alid_pkg::POS_W-1:0]   found_index_o,
  output logic [alid_pkg::DATA_W-1:0]  read_data_o,
  output logic [alid_pkg::COUNT_W-1:0] count_o
);
  import alid_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [ELEM_WIDTH-1:0] mem_q [DEPTH];

  cmd_e                  cmd_q;
  logic [POS_W-1:0]      pos_q;
  logic [ELEM_WIDTH-1:0] elem_q;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         ptr_q, ptr_d;
  logic [ELEM_WIDTH-1:0] rd_data_q;
  logic [AW-1:0]         rd_ptr_q;
  logic                  rd_vld_q;
  stat_e                 stat_q;
  logic [POS_W-1:0]      idx_q;
  logic [DATA_W-1:0]     data_q;
  stat_e                 res_stat_q;
  logic [POS_W-1:0]      res_idx_q;
  logic [DATA_W-1:0]     res_data_q;
  logic [COUNT_W-1:0]    res_cnt_q;

  logic [CMPW-1:0]       pos_x, cnt_x;
  logic                  full, reject, need_shift;
  logic [AW-1:0]         first_src, last_src;
  logic [AW-1:0]         wr_addr;
  logic [ELEM_WIDTH-1:0] wr_data;

  assign pos_x = CMPW'(pos_q);
  assign cnt_x = CMPW'(count_q);
  assign full  = (count_q == CW'(DEPTH));

  always_comb begin
    reject     = 1'b1;
    need_shift = 1'b0;
    first_src  = AW'(pos_q);
    last_src   = AW'(pos_q);
    unique case (cmd_q)
      CMD_APPEND: reject = full;
      CMD_INSERT: begin
        reject     = full || (pos_x > cnt_x);
        need_shift = (pos_x < cnt_x);
        first_src  = AW'(cnt_x - CMPW'(1));
      end
      CMD_DELETE: begin
        reject     = (pos_x >= cnt_x);
        need_shift = ((pos_x + CMPW'(1)) < cnt_x);
        first_src  = AW'(pos_x + CMPW'(1));
        last_src   = AW'(cnt_x - CMPW'(1));
      end
      CMD_SEARCH: begin
        reject    = 1'b0;
        first_src = '0;
        last_src  = AW'(cnt_x - CMPW'(1));
      end
      CMD_READ:   reject = (pos_x >= cnt_x);
      default:    reject = 1'b1;
    endcase
  end

  // Inserts walk downwards so that no entry is overwritten before it moves.
  always_comb begin
    ptr_d = ptr_q;
    if (ctl_i.ptr_init) begin
      ptr_d = first_src;
    end else if (ctl_i.ptr_step) begin
      ptr_d = (cmd_q == CMD_INSERT) ? ptr_q - AW'(1) : ptr_q + AW'(1);
    end
  end

  always_comb begin
    wr_addr = AW'(count_q);
    wr_data = elem_q;
    unique case (ctl_i.wr_mode)
      WR_TAIL: wr_addr = AW'(count_q);
      WR_POS:  wr_addr = AW'(pos_q);
      WR_SHIFT: begin
        wr_addr = (cmd_q == CMD_INSERT) ? rd_ptr_q + AW'(1) : rd_ptr_q - AW'(1);
        wr_data = rd_data_q;
      end
      default: wr_addr = AW'(count_q);
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (ctl_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (ctl_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      rd_vld_q <= ctl_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (ctl_i.rd_en) begin
      rd_ptr_q <= ptr_q;
    end
    if (ctl_i.load) begin
      cmd_q  <= cmd_e'(command_i);
      pos_q  <= position_i;
      elem_q <= ELEM_WIDTH'(element_i);
      idx_q  <= '0;
      data_q <= '0;
    end else begin
      if (ctl_i.cap_idx) begin
        idx_q <= POS_W'(rd_ptr_q);
      end
      if (ctl_i.cap_data) begin
        data_q <= DATA_W'(rd_data_q);
      end
    end
    if (ctl_i.stat_wr) begin
      stat_q <= ctl_i.stat;
    end
    if (ctl_i.out_load) begin
      res_stat_q <= stat_q;
      res_idx_q  <= idx_q;
      res_data_q <= data_q;
      res_cnt_q  <= COUNT_W'(count_q);
    end
  end

  assign sts_o.cmd        = cmd_q;
  assign sts_o.reject     = reject;
  assign sts_o.need_shift = need_shift;
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.at_last    = (ptr_q == last_src);
  assign sts_o.rd_vld     = rd_vld_q;
  assign sts_o.match      = rd_vld_q && (rd_data_q == elem_q);

  assign status_o      = res_stat_q;
  assign found_index_o = res_idx_q;
  assign read_data_o   = res_data_q;
  assign count_o       = res_cnt_q;

endmodule

// ----- rtl/core/alid_ctrl.sv -----
// ----------------------------------------------------------------------------
// alid_ctrl
// Controller of the array list: sequences the check, the memory walk and the
// delivery of each command's result.
// ----------------------------------------------------------------------------
module alid_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  alid_pkg::sts_t sts_i,
  output alid_pkg::ctl_t ctl_o
);
  import alid_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_RUN    = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_PUT    = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       shift_cmd;

  assign shift_cmd = (sts_i.cmd == CMD_INSERT) || (sts_i.cmd == CMD_DELETE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    ctl_o.wr_mode = WR_TAIL;
    ctl_o.stat    = ST_DONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        ctl_o.stat_wr  = 1'b1;
        ctl_o.ptr_init = 1'b1;
        if (sts_i.reject) begin
          ctl_o.stat = ST_REJECT;
          state_d    = S_FINISH;
        end else begin
          unique case (sts_i.cmd)
            CMD_APPEND: begin
              ctl_o.wr_en   = 1'b1;
              ctl_o.cnt_inc = 1'b1;
              state_d       = S_FINISH;
            end
            CMD_INSERT: state_d = sts_i.need_shift ? S_RUN : S_PUT;
            CMD_DELETE: begin
              if (sts_i.need_shift) begin
                state_d = S_RUN;
              end else begin
                ctl_o.cnt_dec = 1'b1;
                state_d       = S_FINISH;
              end
            end
            CMD_SEARCH: begin
              ctl_o.stat = ST_NOT_FOUND;
              state_d    = sts_i.empty ? S_FINISH : S_RUN;
            end
            CMD_READ: state_d = S_RUN;
            default:  state_d = S_FINISH;
          endcase
        end
      end
      // One read a cycle; for insert and delete each entry read is written back in the next cycle.
      S_RUN: begin
        ctl_o.rd_en    = 1'b1;
        ctl_o.ptr_step = !sts_i.at_last;
        ctl_o.wr_mode  = WR_SHIFT;
        ctl_o.wr_en    = shift_cmd && sts_i.rd_vld;
        if (sts_i.at_last) begin
          state_d = S_DRAIN;
        end
        if ((sts_i.cmd == CMD_SEARCH) && sts_i.match) begin
          ctl_o.cap_idx = 1'b1;
          ctl_o.stat_wr = 1'b1;
          state_d       = S_FINISH;
        end
      end
      S_DRAIN: begin
        ctl_o.wr_mode = WR_SHIFT;
        ctl_o.wr_en   = shift_cmd;
        state_d       = S_FINISH;
        unique case (sts_i.cmd)
          CMD_INSERT: state_d = S_PUT;
          CMD_DELETE: ctl_o.cnt_dec = 1'b1;
          CMD_SEARCH: begin
            ctl_o.cap_idx = sts_i.match;
            ctl_o.stat_wr = sts_i.match;
          end
          CMD_READ: ctl_o.cap_data = 1'b1;
          default:  state_d = S_FINISH;
        endcase
      end
      S_PUT: begin
        ctl_o.wr_mode = WR_POS;
        ctl_o.wr_en   = 1'b1;
        ctl_o.cnt_inc = 1'b1;
        state_d       = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/alid_chk.sv -----
// ----------------------------------------------------------------------------
// alid_chk
// Port-level checks of the array list, bound to the top level.
// ----------------------------------------------------------------------------
module alid_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [alid_pkg::CMD_W-1:0]   command_i,
  input logic [alid_pkg::POS_W-1:0]   position_i,
  input logic [alid_pkg::DATA_W-1:0]  element_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [alid_pkg::STAT_W-1:0]  status_o,
  input logic [alid_pkg::POS_W-1:0]   found_index_o,
  input logic [alid_pkg::DATA_W-1:0]  read_data_o,
  input logic [alid_pkg::COUNT_W-1:0] count_o
);
  import alid_pkg::*;

  logic [COUNT_W-1:0] last_cnt_q;
  logic               in_seen;

  // Count reported by the last delivered result transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cnt_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      last_cnt_q <= count_o;
    end
  end

  assign in_seen = in_valid_i && !in_stall_o && (command_i != '0 || position_i != '0 ||
                                                 element_i != '0 || 1'b1);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(count_o) && $stable(read_data_o) && $stable(found_index_o))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_seen |=> in_stall_o)
    else $error("second command taken while one is in progress");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_DONE) |-> (found_index_o == '0) && (read_data_o == '0))
    else $error("index or data set on an unsuccessful command");

  a_count_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == ST_REJECT) || (status_o == ST_NOT_FOUND))
      |-> (count_o == last_cnt_q))
    else $error("count changed by a command that made no change");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o == last_cnt_q) || (count_o == last_cnt_q + 7'd1) ||
      (count_o == last_cnt_q - 7'd1))
    else $error("count moved by more than one entry");

endmodule

bind array_list_insert_delete alid_chk u_alid_chk (.*);
